// ----- design/lcc_pkg.sv -----
package lcc_pkg;

	localparam int HIST_DEPTH = 1024;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int OUT_SHIFT  = 32;

	// The quotient is sum * 2^OUT_SHIFT over den * 2^30; the common 2^30 cancels.
	localparam int DEN_SHIFT  = 30;
	localparam int NUM_SHIFT  = OUT_SHIFT - DEN_SHIFT;

	localparam int SAMP_W  = 16;
	localparam int LAG_W   = 10;
	localparam int MSAMP_W = 11;
	localparam int OUT_W   = 48;

	// atten = max_lag + min_prod, and count never exceeds atten.
	localparam int CNT_W  = MSAMP_W + 1;
	localparam int A2_W   = 2 * CNT_W;
	localparam int A4_W   = 2 * A2_W;
	localparam int DEN_W  = A4_W + CNT_W;
	localparam int PROD_W = 2 * SAMP_W;
	localparam int ACC_W  = PROD_W + 1 + CNT_W + 1;
	localparam int NUM_W  = ACC_W + NUM_SHIFT;
	localparam int BIT_W  = $clog2(NUM_W);

	localparam logic [1:0] REG_MIN_LAG  = 2'd0;
	localparam logic [1:0] REG_MAX_LAG  = 2'd1;
	localparam logic [1:0] REG_MIN_PROD = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEN1,
		ST_DEN2,
		ST_DEN3,
		ST_MAC,
		ST_DRAIN,
		ST_DIV_LD,
		ST_DIV_RUN,
		ST_DIV_END,
		ST_FIN
	} state_t;

endpackage

// ----- design/lagged_complex_cross_correlator.sv -----
// Channel | Direction | Signals
// input   | in        | in_valid, in_ready, lead_re, lead_im, lag_re, lag_im, lag_select
// result  | out       | out_valid, out_ready, corr_re, corr_im
// config  | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// For each item, count = max_lag + min_prod - tau: one
// complex multiply-accumulate per history entry through the single MAC unit, then
// a bit-serial restoring divider that runs once for the real and once for the
// imaginary part. An empty window skips both and goes straight to the result. After
// reset a clearing pass over all HIST_DEPTH entries zeroes both histories; in_ready stays low
// meanwhile. A stalled result waits in the output register; the next item is
// accepted while it waits, and its own result is held back until the register frees.
module lagged_complex_cross_correlator
	import lcc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SAMP_W-1:0]  lead_re,
	input  logic signed [SAMP_W-1:0]  lead_im,
	input  logic signed [SAMP_W-1:0]  lag_re,
	input  logic signed [SAMP_W-1:0]  lag_im,
	input  logic        [LAG_W-1:0]   lag_select,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [OUT_W-1:0]   corr_re,
	output logic signed [OUT_W-1:0]   corr_im,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic        [1:0]         cfg_index,
	input  logic        [MSAMP_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [LAG_W-1:0]   min_lag_q, max_lag_q;
	logic [MSAMP_W-1:0] min_prod_q;

	logic [HIST_AW-1:0] clr_q, wp_q, wp_next;
	logic [LAG_W-1:0]   tau_q, tau_c;
	logic [CNT_W-1:0]   atten_q, count_q, t_q, atten_c, count_c;
	logic [A2_W-1:0]    a2_q;
	logic [A4_W-1:0]    a4_q;
	logic [DEN_W-1:0]   den_q;

	logic [2*SAMP_W-1:0] lead_mem [HIST_DEPTH];
	logic [2*SAMP_W-1:0] lag_mem  [HIST_DEPTH];
	logic [2*SAMP_W-1:0] lead_rd_s1, lag_rd_s1;
	logic [HIST_AW-1:0]  gaddr, laddr;
	logic                v_s1, v_s2;
	logic signed [PROD_W-1:0] p_rr_s2, p_mm_s2, p_rm_s2, p_mr_s2;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;

	logic                 sel_q;
	logic [DEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     num_q, quo_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 neg_q;
	logic [DEN_W:0]       rs;
	logic                 ge;
	logic signed [ACC_W-1:0] acc_sel;
	logic [ACC_W-1:0]     mag;
	logic [NUM_W-1:0]     lim, qsat;
	logic signed [OUT_W-1:0] res_val, res_re_q, res_im_q, q_re_q, q_im_q;
	logic                 out_valid_q;
	logic                 out_load;

	logic in_acc, issue, wr_en;
	logic [HIST_AW-1:0]  wr_addr;
	logic [2*SAMP_W-1:0] wr_lead, wr_lag;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign corr_re   = res_re_q;
	assign corr_im   = res_im_q;
	assign in_acc    = in_valid && in_ready;
	assign wp_next   = wp_q + 1'b1;
	assign out_load  = (state_q == ST_FIN) && !out_valid_q;

	always_comb begin
		tau_c = lag_select;
		if (tau_c < min_lag_q) tau_c = min_lag_q;
		if (tau_c > max_lag_q) tau_c = max_lag_q;
		atten_c = CNT_W'(max_lag_q) + CNT_W'(min_prod_q);
		count_c = atten_c - CNT_W'(tau_c);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == HIST_AW'(HIST_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) state_d = (count_c == '0) ? ST_FIN : ST_DEN1;
			end
			ST_DEN1:    state_d = ST_DEN2;
			ST_DEN2:    state_d = ST_DEN3;
			ST_DEN3:    state_d = ST_MAC;
			ST_MAC:     if (t_q == count_q - 1'b1) state_d = ST_DRAIN;
			ST_DRAIN:   if (!v_s1 && !v_s2) state_d = ST_DIV_LD;
			ST_DIV_LD:  state_d = ST_DIV_RUN;
			ST_DIV_RUN: if (bit_q == '0) state_d = ST_DIV_END;
			ST_DIV_END: state_d = sel_q ? ST_FIN : ST_DIV_LD;
			ST_FIN:     if (!out_valid_q) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_MAC);
		wr_en    = (state_q == ST_CLEAR) || in_acc;
		wr_addr  = (state_q == ST_CLEAR) ? clr_q : wp_next;
		wr_lead  = (state_q == ST_CLEAR) ? '0 : {lead_re, lead_im};
		wr_lag   = (state_q == ST_CLEAR) ? '0 : {lag_re, lag_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			min_lag_q   <= '0;
			max_lag_q   <= LAG_W'(512);
			min_prod_q  <= MSAMP_W'(256);
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (in_acc) wp_q <= wp_next;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_LAG:  min_lag_q  <= cfg_data[LAG_W-1:0];
					REG_MAX_LAG:  max_lag_q  <= cfg_data[LAG_W-1:0];
					REG_MIN_PROD: min_prod_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			else if (out_load) out_valid_q <= 1'b1;
		end
	end

	// Histories: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (wr_en) lead_mem[wr_addr] <= wr_lead;
		lead_rd_s1 <= lead_mem[laddr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) lag_mem[wr_addr] <= wr_lag;
		lag_rd_s1 <= lag_mem[gaddr];
	end

	// Ring indices wrap on the power-of-two depth.
	assign gaddr = wp_q - t_q[HIST_AW-1:0];
	assign laddr = gaddr - HIST_AW'(tau_q);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tau_q    <= tau_c;
			atten_q  <= atten_c;
			count_q  <= count_c;
			acc_re_q <= '0;
			acc_im_q <= '0;
			q_re_q   <= '0;
			q_im_q   <= '0;
			t_q      <= '0;
			sel_q    <= 1'b0;
		end
		if (state_q == ST_DEN1) a2_q  <= atten_q * atten_q;
		if (state_q == ST_DEN2) a4_q  <= a2_q * a2_q;
		if (state_q == ST_DEN3) den_q <= a4_q * count_q;
		if (issue) t_q <= t_q + 1'b1;
		if (v_s1) begin
			p_rr_s2 <= $signed(lead_rd_s1[2*SAMP_W-1:SAMP_W])
				* $signed(lag_rd_s1[2*SAMP_W-1:SAMP_W]);
			p_mm_s2 <= $signed(lead_rd_s1[SAMP_W-1:0]) * $signed(lag_rd_s1[SAMP_W-1:0]);
			p_rm_s2 <= $signed(lead_rd_s1[2*SAMP_W-1:SAMP_W])
				* $signed(lag_rd_s1[SAMP_W-1:0]);
			p_mr_s2 <= $signed(lead_rd_s1[SAMP_W-1:0])
				* $signed(lag_rd_s1[2*SAMP_W-1:SAMP_W]);
		end
		if (v_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(p_rr_s2) + ACC_W'(p_mm_s2);
			acc_im_q <= acc_im_q + ACC_W'(p_rm_s2) - ACC_W'(p_mr_s2);
		end
		if (state_q == ST_DIV_LD) begin
			neg_q <= acc_sel[ACC_W-1];
			num_q <= {mag, {NUM_SHIFT{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= BIT_W'(NUM_W - 1);
		end
		if (state_q == ST_DIV_RUN) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(rs - {1'b0, den_q}) : rs[DEN_W-1:0];
			bit_q <= bit_q - 1'b1;
		end
		if (state_q == ST_DIV_END) begin
			if (sel_q) q_im_q <= res_val;
			else q_re_q <= res_val;
			sel_q <= 1'b1;
		end
		// The output register only takes a new result once the last one has gone.
		if (out_load) begin
			res_re_q <= q_re_q;
			res_im_q <= q_im_q;
		end
	end

	always_comb begin
		acc_sel = sel_q ? acc_im_q : acc_re_q;
		mag     = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
		rs      = {rem_q, num_q[NUM_W-1]};
		ge      = (rs >= {1'b0, den_q});
		lim     = neg_q ? NUM_W'(64'd1 << (OUT_W - 1)) : NUM_W'((64'd1 << (OUT_W - 1)) - 1);
		qsat    = (quo_q > lim) ? lim : quo_q;
		res_val = neg_q ? OUT_W'(-qsat) : OUT_W'(qsat);
	end

endmodule

// ----- design/lcc_checker.sv -----
module lcc_checker
	import lcc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [OUT_W-1:0]  corr_re,
	input logic [OUT_W-1:0]  corr_im,
	input logic              cfg_ready
);

	// A held result keeps its value until the transaction completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(corr_re) && $stable(corr_im))
		else $error("held result changed");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted during computation");

	// No result appears in the cycle right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port stalled");

endmodule

bind lagged_complex_cross_correlator lcc_checker u_lcc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .corr_re(corr_re),
	.corr_im(corr_im), .cfg_ready(cfg_ready)
);
